// ===== rtl/wgm_pkg.sv =====
// Shared constants, types and helpers for the wildcard glob matcher.
// No dependencies; every other RTL file except wgm_closure imports this package.
`default_nettype none

package wgm_pkg;

   localparam int PATTERN_MAX_DEFAULT = 32;  // pattern positions tracked
   localparam int HELD_CHARS          = 32;  // pattern chars held in registers
   localparam int CHAR_W              = 8;
   localparam int WORD_W              = 64;
   localparam int CHARS_PER_WORD      = WORD_W / CHAR_W;
   localparam int WORDS               = HELD_CHARS / CHARS_PER_WORD;
   localparam int WORD_IDX_W          = $clog2(WORDS);
   localparam int LEN_W               = 6;
   localparam int CSR_INDEX_W         = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_LENGTH = 3'd0,
      CSR_PATTERN_WORD_0 = 3'd1,
      CSR_PATTERN_WORD_1 = 3'd2,
      CSR_PATTERN_WORD_2 = 3'd3,
      CSR_PATTERN_WORD_3 = 3'd4
   } csr_index_type;

   localparam logic [CHAR_W-1:0] CHAR_STAR    = 8'h2A;  // '*'
   localparam logic [CHAR_W-1:0] CHAR_ANY     = 8'h3F;  // '?'
   localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;  // 'a'
   localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;  // 'z'
   localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;

   // decoded view of one pattern position
   typedef struct packed {
      logic              used;        // position lies below the effective length
      logic              star;
      logic              any;
      logic [CHAR_W-1:0] upper_char;
   } pos_type;

   function automatic logic [CHAR_W-1:0] to_upper(input logic [CHAR_W-1:0] c);
      if ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z)) begin
         return c - CASE_OFFSET;
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/wgm_closure.sv =====
// Star closure of a position vector: a live star position also makes the next one live.
// Log-depth prefix network; no package dependencies.
`default_nettype none

module wgm_closure #(
   parameter int POSITIONS = 33
) (
   input  logic [POSITIONS-1:0] seed,
   input  logic [POSITIONS-1:0] allow,
   input  logic [POSITIONS-2:0] star,
   output logic [POSITIONS-1:0] closed
);

   localparam int LEVELS = $clog2(POSITIONS);

   // carry-style prefix: gen = live, prop[j] = star at position j-1
   always_comb begin
      logic [POSITIONS-1:0] gen;
      logic [POSITIONS-1:0] prop;
      gen  = seed & allow;
      prop = {star, 1'b0};
      for (int l = 0; l < LEVELS; l++) begin
         // descending so lower entries still hold the previous level
         for (int j = POSITIONS - 1; j >= (1 << l); j--) begin
            gen[j]  = gen[j] | (prop[j] & gen[j - (1 << l)]);
            prop[j] = prop[j] & prop[j - (1 << l)];
         end
      end
      closed = gen;
   end

endmodule

`default_nettype wire

// ===== rtl/wgm_csr.sv =====
// Pattern configuration registers and per-position decode.
// Depends on wgm_pkg.
`default_nettype none

module wgm_csr #(
   parameter int PATTERN_MAX = wgm_pkg::PATTERN_MAX_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [wgm_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [wgm_pkg::WORD_W-1:0]            csr_write_data,
   output wgm_pkg::pos_type [PATTERN_MAX-1:0]    pattern_pos
);

   import wgm_pkg::*;

   logic [LEN_W-1:0]  length_ff;
   logic [LEN_W-1:0]  length_in;
   logic [WORD_W-1:0] word_ff [WORDS];
   logic [WORD_W-1:0] word_in [WORDS];

   always_comb begin
      length_in = length_ff;
      for (int w = 0; w < WORDS; w++) begin
         word_in[w] = word_ff[w];
      end
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PATTERN_LENGTH: length_in  = csr_write_data[LEN_W-1:0];
            CSR_PATTERN_WORD_0: word_in[0] = csr_write_data;
            CSR_PATTERN_WORD_1: word_in[1] = csr_write_data;
            CSR_PATTERN_WORD_2: word_in[2] = csr_write_data;
            CSR_PATTERN_WORD_3: word_in[3] = csr_write_data;
            default: ;  // unknown index: dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
         for (int w = 0; w < WORDS; w++) begin
            word_ff[w] <= '0;
         end
      end else begin
         length_ff <= length_in;
         for (int w = 0; w < WORDS; w++) begin
            word_ff[w] <= word_in[w];
         end
      end
   end

   logic [CHAR_W-1:0]      pat_char [PATTERN_MAX];
   logic [PATTERN_MAX-1:0] nonzero;

   always_comb begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
         if (k < HELD_CHARS) begin
            pat_char[k] = word_ff[WORD_IDX_W'(k / CHARS_PER_WORD)]
                                 [(k % CHARS_PER_WORD) * CHAR_W +: CHAR_W];
         end else begin
            pat_char[k] = CHAR_NUL;
         end
         nonzero[k] = (pat_char[k] != CHAR_NUL);
      end
   end

   // a position is used when below the length and no NUL at or before it
   always_comb begin
      logic [PATTERN_MAX-1:0] low_mask;
      for (int k = 0; k < PATTERN_MAX; k++) begin
         for (int j = 0; j < PATTERN_MAX; j++) begin
            low_mask[j] = (j <= k);
         end
         pattern_pos[k].used       = (LEN_W'(k) < length_ff) && (&(nonzero | ~low_mask));
         pattern_pos[k].star       = (pat_char[k] == CHAR_STAR);
         pattern_pos[k].any        = (pat_char[k] == CHAR_ANY);
         pattern_pos[k].upper_char = to_upper(pat_char[k]);
      end
   end

endmodule

`default_nettype wire

// ===== rtl/wgm_step.sv =====
// Position-vector update for one subject character, plus end-of-string match.
// Depends on wgm_pkg and wgm_closure.
`default_nettype none

module wgm_step #(
   parameter int PATTERN_MAX = wgm_pkg::PATTERN_MAX_DEFAULT
) (
   input  wgm_pkg::pos_type [PATTERN_MAX-1:0] pattern_pos,
   input  logic [PATTERN_MAX:0]               state,
   input  logic [wgm_pkg::CHAR_W-1:0]         subject_char,
   input  logic                               end_of_string,
   output logic [PATTERN_MAX:0]               next_state,
   output logic                               matched
);

   import wgm_pkg::*;

   logic [PATTERN_MAX-1:0] used;
   logic [PATTERN_MAX-1:0] star_live;
   logic [PATTERN_MAX:0]   allow;
   logic [PATTERN_MAX:0]   live;
   logic [PATTERN_MAX:0]   advanced;
   logic [PATTERN_MAX:0]   advanced_closed;
   logic [CHAR_W-1:0]      subject_upper;

   always_comb begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
         used[i]      = pattern_pos[i].used;
         star_live[i] = pattern_pos[i].used & pattern_pos[i].star;
      end
      allow = {used, 1'b1};
   end

   // reclose with the current pattern, which may have changed since the last item
   wgm_closure #(.POSITIONS(PATTERN_MAX + 1)) u_close_in (
      .seed   (state),
      .allow  (allow),
      .star   (star_live),
      .closed (live)
   );

   assign subject_upper = to_upper(subject_char);

   always_comb begin
      advanced = '0;
      for (int i = 0; i < PATTERN_MAX; i++) begin
         if (used[i] && live[i]) begin
            if (pattern_pos[i].star) begin
               advanced[i] = 1'b1;
            end else if (pattern_pos[i].any || (pattern_pos[i].upper_char == subject_upper)) begin
               advanced[i + 1] = 1'b1;
            end
         end
      end
   end

   wgm_closure #(.POSITIONS(PATTERN_MAX + 1)) u_close_out (
      .seed   (advanced),
      .allow  (allow),
      .star   (star_live),
      .closed (advanced_closed)
   );

   // the end position is the only allowed one that is not used
   assign matched = |(live & allow & ~{1'b0, used});

   assign next_state = end_of_string ? (PATTERN_MAX + 1)'(1) : advanced_closed;

endmodule

`default_nettype wire

// ===== rtl/wildcard_glob_matcher.sv =====
// Wildcard glob matcher: stage register, then result register driving rsp_valid.
// Throughput one subject character per cycle unless an end-of-string waits on a
// held response; set by the star closure and position-vector update between the
// stage and state registers. Reset (synchronous): pattern length and words cleared,
// only position 0 live, stage and result registers empty.
`default_nettype none

module wildcard_glob_matcher #(
   parameter int PATTERN_MAX = wgm_pkg::PATTERN_MAX_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel: one subject character or an end-of-string marker
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [wgm_pkg::CHAR_W-1:0]       req_subject_char,
   input  logic                             req_end_of_string,
   // response channel: one transaction per end-of-string
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_matched,
   // configuration write port
   input  logic                             csr_write_enable,
   input  logic [wgm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [wgm_pkg::WORD_W-1:0]       csr_write_data
);

   import wgm_pkg::*;

   pos_type [PATTERN_MAX-1:0] pattern_pos;

   wgm_csr #(.PATTERN_MAX(PATTERN_MAX)) u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .pattern_pos      (pattern_pos)
   );

   // stage register: holds the accepted transaction while it is evaluated
   logic              stage_valid_ff, stage_valid_in;
   logic [CHAR_W-1:0] stage_char_ff, stage_char_in;
   logic              stage_eos_ff, stage_eos_in;

   // live pattern positions, kept closed over stars
   logic [PATTERN_MAX:0] state_ff, state_in;

   // result register
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_matched_ff, rsp_matched_in;

   logic [PATTERN_MAX:0] step_next;
   logic                 step_matched;
   logic                 advance;

   wgm_step #(.PATTERN_MAX(PATTERN_MAX)) u_step (
      .pattern_pos   (pattern_pos),
      .state         (state_ff),
      .subject_char  (stage_char_ff),
      .end_of_string (stage_eos_ff),
      .next_state    (step_next),
      .matched       (step_matched)
   );

   // A character retires unconditionally; an end-of-string needs a free
   // result slot, or one being drained this cycle.
   assign advance   = stage_valid_ff && (!stage_eos_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !stage_valid_ff || advance;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_char_in  = stage_char_ff;
      stage_eos_in   = stage_eos_ff;
      if (req_ready) begin
         stage_valid_in = req_valid;
         if (req_valid) begin
            stage_char_in = req_subject_char;
            stage_eos_in  = req_end_of_string;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      if (advance) begin
         state_in = step_next;
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_matched_in = rsp_matched_ff;
      if (advance && stage_eos_ff) begin
         rsp_valid_in   = 1'b1;
         rsp_matched_in = step_matched;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         state_ff       <= (PATTERN_MAX + 1)'(1);
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         state_ff       <= state_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      stage_char_ff  <= stage_char_in;
      stage_eos_ff   <= stage_eos_in;
      rsp_matched_ff <= rsp_matched_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_matched = rsp_matched_ff;

`ifndef ASSERT_OFF
   // an end-of-string that retires always shows up as a response
   a_eos_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (advance && stage_eos_ff) |=> rsp_valid)
      else $error("end-of-string retired without a response");

   // a finished string restarts at position zero only
   a_eos_restarts: assert property (@(posedge clock) disable iff (reset)
      (advance && stage_eos_ff) |=> (state_ff == (PATTERN_MAX + 1)'(1)))
      else $error("state not restarted after end-of-string");

   // the only back-pressure is an end-of-string blocked by a held response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (stage_valid_ff && stage_eos_ff && rsp_valid && !rsp_ready))
      else $error("request stalled without a blocked response");

   // the state moves only when a transaction retires
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("state changed with no retiring transaction");
`endif

endmodule

`default_nettype wire
